// File: rtl/diff_drive_odometry_macros.svh
// Assertion macros for the differential-drive odometry block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef DIFF_DRIVE_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_MACROS_SVH

// same-cycle implication
`define DOD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DOD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/dod_pkg.sv
// Shared types and constants for the differential-drive odometry block.
// No dependencies.
package dod_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_SUM,
		ST_SAT,
		ST_MUL2,
		ST_RND,
		ST_UPD,
		ST_MUL3,
		ST_DIVS,
		ST_DIV,
		ST_DONE
	} st_t;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_MPT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MPT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PM  = 2'd2;

	localparam int DT_W  = 20;
	localparam int NUM_W = 54;   // (|v| * 1e6) >> 8
	localparam int QUO_W = 31;
	localparam int HI_W  = NUM_W - QUO_W;

	localparam logic [DT_W-1:0] US_PER_S = 20'd1000000;

	localparam logic signed [65:0] STEP_LIMIT     = 66'sd1099511627776;
	localparam logic signed [65:0] STEP_LIMIT_NEG = -66'sd1099511627776;
	localparam logic [63:0]        ANGLE_LIMIT    = 64'd2199023255552;

	localparam logic signed [37:0] POS_MAX = 38'sd2147483647;
	localparam logic signed [37:0] POS_MIN = -38'sd2147483648;
	localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

	localparam int CORDIC_STEPS = 16;
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	typedef struct packed {
		logic               done;
		logic signed [31:0] cos_v;
		logic signed [31:0] sin_v;
	} cor_out_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quo;
	} div_out_t;

	// atan(2^-i) in turns * 2^32
	function automatic logic signed [32:0] atan_step(input logic [3:0] i);
		logic signed [32:0] a;
		unique case (i)
			4'd0:  a = 33'sh020000000;
			4'd1:  a = 33'sh012E4051E;
			4'd2:  a = 33'sh009FB385B;
			4'd3:  a = 33'sh0051111D4;
			4'd4:  a = 33'sh0028B0D43;
			4'd5:  a = 33'sh00145D7E1;
			4'd6:  a = 33'sh000A2F61E;
			4'd7:  a = 33'sh000517C55;
			4'd8:  a = 33'sh00028BE53;
			4'd9:  a = 33'sh000145F2F;
			4'd10: a = 33'sh0000A2F98;
			4'd11: a = 33'sh0000517CC;
			4'd12: a = 33'sh000028BE6;
			4'd13: a = 33'sh0000145F3;
			4'd14: a = 33'sh00000A2FA;
			4'd15: a = 33'sh00000517D;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/dod_ifs.sv
// Valid/ready channel interfaces: encoder counts in, pose out, config writes.
// Depends on dod_pkg.
interface dod_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_count;
	logic signed [15:0] right_count;
	logic [19:0]        elapsed_us;
	modport source(output valid, left_count, right_count, elapsed_us, input ready);
	modport sink(input valid, left_count, right_count, elapsed_us, output ready);
endinterface

interface dod_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position_x;
	logic signed [31:0] position_y;
	logic [15:0]        heading_out;
	logic signed [31:0] linear_velocity;
	logic signed [31:0] angular_velocity;
	logic               zero_interval;
	modport source(output valid, position_x, position_y, heading_out, linear_velocity,
		angular_velocity, zero_interval, input ready);
	modport sink(input valid, position_x, position_y, heading_out, linear_velocity,
		angular_velocity, zero_interval, output ready);
endinterface

interface dod_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [dod_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                   data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/dod_cordic.sv
// Iterative 16-step CORDIC, one rotation per cycle, for cos/sin of the heading.
// Depends on dod_pkg.
module dod_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [15:0]       heading,
	output dod_pkg::cor_out_t res
);
	logic               run_q;
	logic               done_q;
	logic [3:0]         i_q;
	logic               flip_q;
	logic signed [32:0] x_q;
	logic signed [32:0] y_q;
	logic signed [32:0] z_q;

	logic [31:0]        a0;
	logic [31:0]        a1;
	logic               flip;
	logic signed [32:0] dx;
	logic signed [32:0] dy;
	logic signed [32:0] at;

	always_comb begin
		a0   = {heading, 16'h0000};
		a1   = a0 + 32'h4000_0000;
		flip = a1[31];
		dx   = y_q >>> i_q;
		dy   = x_q >>> i_q;
		at   = dod_pkg::atan_step(i_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				i_q <= i_q + 4'd1;
				if (i_q == 4'(dod_pkg::CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= flip;
			x_q    <= dod_pkg::CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= 33'(signed'(flip ? a0 + 32'h8000_0000 : a0));
		end else if (run_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign res.done  = done_q;
	assign res.cos_v = 32'(flip_q ? -x_q : x_q);
	assign res.sin_v = 32'(flip_q ? -y_q : y_q);
endmodule

// File: rtl/dod_div.sv
// Restoring divider, one quotient bit per cycle, with overflow prescreen and
// signed saturation to 32 bits. Depends on dod_pkg.
module dod_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dod_pkg::NUM_W-1:0]  num,
	input  logic [dod_pkg::DT_W-1:0]   den,
	input  logic                       neg,
	output dod_pkg::div_out_t          res
);
	logic                          run_q;
	logic                          done_q;
	logic [4:0]                    cnt_q;
	logic [dod_pkg::DT_W-1:0]      rem_q;
	logic [dod_pkg::DT_W-1:0]      den_q;
	logic [dod_pkg::QUO_W-1:0]     quo_q;
	logic                          neg_q;
	logic                          ovf_q;

	logic [dod_pkg::HI_W-1:0]      hi;
	logic [dod_pkg::DT_W:0]        r2;
	logic [dod_pkg::DT_W:0]        rd;
	logic                          ge;
	logic signed [31:0]            mag;

	always_comb begin
		hi  = num[dod_pkg::NUM_W-1:dod_pkg::QUO_W];
		r2  = {rem_q, quo_q[dod_pkg::QUO_W-1]};
		rd  = r2 - {1'b0, den_q};
		ge  = r2 >= {1'b0, den_q};
		mag = signed'({1'b0, quo_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(dod_pkg::QUO_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= hi >= dod_pkg::HI_W'(den);
			rem_q <= hi[dod_pkg::DT_W-1:0];
			quo_q <= num[dod_pkg::QUO_W-1:0];
			den_q <= den;
			neg_q <= neg;
		end else if (run_q) begin
			rem_q <= ge ? rd[dod_pkg::DT_W-1:0] : r2[dod_pkg::DT_W-1:0];
			quo_q <= {quo_q[dod_pkg::QUO_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quo  = ovf_q ? (neg_q ? dod_pkg::INT32_MIN : dod_pkg::INT32_MAX)
	                        : (neg_q ? -mag : mag);
endmodule

// File: rtl/diff_drive_odometry.sv
// Differential-drive odometry top level: bit-serial multipliers, CORDIC, dividers.
// Depends on dod_pkg, dod_ifs, dod_cordic, dod_div and the assertion macros.
//
//  channel  dir   word
//  -------  ----  ----------------------------------------------------------
//  cfg      in    index, data (meters/tick left, right; angle per meter)
//  counts   in    left_count, right_count, elapsed_us
//  pose     out   position_x/y, heading_out, linear/angular_velocity, zero_interval
//
// Counts is not ready again until the word's pose result is valid; both rise in the
// same cycle. The pace is set by three 1-bit shift-add multiplier passes
// and the 31-step restoring dividers.
// arst_n clears configuration, last counts, pose and heading.
// A stalled pose word sits in the output register; the datapath then holds its
// result until the register frees, and counts stays not ready meanwhile.
`include "diff_drive_odometry_macros.svh"

module diff_drive_odometry #(
	parameter int COUNT_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	dod_in_if.sink     counts,
	dod_out_if.source  pose,
	dod_cfg_if.sink    cfg
);
	localparam int PW = COUNT_BITS + 32;   // wheel distance product width

	// configuration
	logic [31:0] lmpt_q;
	logic [31:0] rmpt_q;
	logic [31:0] apm_q;

	// control and persistent state
	dod_pkg::st_t state_q;
	dod_pkg::st_t state_d;
	logic [4:0]   cnt_q;
	logic [4:0]   cnt_d;
	logic [COUNT_BITS-1:0] last_l_q;
	logic [COUNT_BITS-1:0] last_r_q;
	logic signed [31:0]    pose_x_q;
	logic signed [31:0]    pose_y_q;
	logic [15:0]           hd_q;
	logic                  ovld_q;

	// datapath
	logic [dod_pkg::DT_W-1:0]    dt_q;
	logic signed [COUNT_BITS-1:0] dlt_l_q;
	logic signed [COUNT_BITS-1:0] dlt_r_q;
	logic signed [COUNT_BITS:0]   mla_q;
	logic signed [COUNT_BITS:0]   mra_q;
	logic [31:0]                  mlb_q;
	logic [31:0]                  mrb_q;
	logic signed [65:0] d_q;
	logic signed [65:0] diff_q;
	logic signed [33:0] d16_q;
	logic signed [34:0] mxa_q;
	logic signed [34:0] mya_q;
	logic [31:0]        mxb_q;
	logic [31:0]        myb_q;
	logic [63:0]        mag_q;
	logic [64:0]        mqa_q;
	logic [31:0]        mqb_q;
	logic [40:0]        dmag_q;
	logic               lneg_q;
	logic               aneg_q;
	logic signed [36:0] xr_q;
	logic signed [36:0] yr_q;
	logic [41:0]        vl_q;
	logic [41:0]        va_q;
	logic [42:0]        vla_q;
	logic [42:0]        vaa_q;
	logic [19:0]        vlb_q;
	logic [19:0]        vab_q;
	logic signed [31:0] lin_q;
	logic signed [31:0] ang_q;

	// output register
	logic signed [31:0] opx_q;
	logic signed [31:0] opy_q;
	logic [15:0]        ohd_q;
	logic signed [31:0] olin_q;
	logic signed [31:0] oang_q;
	logic               ozi_q;

	// control outputs
	logic accept;
	logic div_start;
	logic load_out;

	// combinational datapath
	logic [COUNT_BITS-1:0]      lc_cb;
	logic [COUNT_BITS-1:0]      rc_cb;
	logic signed [COUNT_BITS:0] sum_l;
	logic signed [COUNT_BITS:0] sum_r;
	logic signed [PW-1:0]       dl;
	logic signed [PW-1:0]       dr;
	logic signed [65:0]         sum_d;
	logic signed [41:0]         dsat;
	logic signed [41:0]         d16_sum;
	logic                       booth_neg;
	logic signed [34:0]         addx;
	logic signed [34:0]         addy;
	logic signed [34:0]         sumx;
	logic signed [34:0]         sumy;
	logic [64:0]                sumq;
	logic signed [66:0]         pxr;
	logic signed [66:0]         pyr;
	logic [95:0]                qprod;
	logic [55:0]                ht;
	logic [63:0]                a8full;
	logic [41:0]                a8;
	logic signed [37:0]         nx;
	logic signed [37:0]         ny;
	logic [42:0]                sumvl;
	logic [42:0]                sumva;
	logic [61:0]                prod_l;
	logic [61:0]                prod_a;

	dod_pkg::cor_out_t cor_o;
	dod_pkg::div_out_t div_l_o;
	dod_pkg::div_out_t div_a_o;

	dod_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.heading (hd_q),
		.res     (cor_o)
	);

	dod_div u_div_lin (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_l[61:8]),
		.den    (dt_q),
		.neg    (lneg_q),
		.res    (div_l_o)
	);

	dod_div u_div_ang (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_a[61:8]),
		.den    (dt_q),
		.neg    (aneg_q),
		.res    (div_a_o)
	);

	assign cfg.ready = 1'b1;

	// ---------------- arithmetic ----------------
	always_comb begin
		// counts widen by sign extension, narrow by truncation, then wrap
		lc_cb = COUNT_BITS'(counts.left_count);
		rc_cb = COUNT_BITS'(counts.right_count);

		// wheel distance: delta * meters_per_tick, LSB first, product shifts into B
		sum_l = mla_q + (mlb_q[0] ? (COUNT_BITS+1)'(dlt_l_q) : '0);
		sum_r = mra_q + (mrb_q[0] ? (COUNT_BITS+1)'(dlt_r_q) : '0);
		dl    = signed'({mla_q[COUNT_BITS-1:0], mlb_q});
		dr    = signed'({mra_q[COUNT_BITS-1:0], mrb_q});
		sum_d = 66'(dl) + 66'(dr);

		// step distance clamp and Q24 -> Q16 round half up
		if (d_q > dod_pkg::STEP_LIMIT)
			dsat = 42'(dod_pkg::STEP_LIMIT);
		else if (d_q < dod_pkg::STEP_LIMIT_NEG)
			dsat = 42'(dod_pkg::STEP_LIMIT_NEG);
		else
			dsat = 42'(d_q);
		d16_sum = dsat + 42'sd128;

		// position: d16 * trig, signed multiplier bit 31 subtracts
		booth_neg = cnt_q == 5'd31;
		addx = mxb_q[0] ? 35'(d16_q) : '0;
		addy = myb_q[0] ? 35'(d16_q) : '0;
		sumx = booth_neg ? mxa_q - addx : mxa_q + addx;
		sumy = booth_neg ? mya_q - addy : mya_q + addy;
		pxr  = signed'({mxa_q, mxb_q}) + 67'sd536870912;
		pyr  = signed'({mya_q, myb_q}) + 67'sd536870912;

		// |dr - dl| * angle_per_meter, full 96-bit product
		sumq  = mqa_q + (mqb_q[0] ? {1'b0, mag_q} : '0);
		qprod = {mqa_q[63:0], mqb_q};
		// heading step: (+-Q + 2^39) bits 55:40, sign folded into one adder
		ht = aneg_q ? (56'h80_0000_0000 - qprod[55:0]) : (qprod[55:0] + 56'h80_0000_0000);
		a8full = qprod[95:32];
		a8 = (a8full > dod_pkg::ANGLE_LIMIT) ? 42'(dod_pkg::ANGLE_LIMIT) : a8full[41:0];

		nx = 38'(pose_x_q) + 38'(xr_q);
		ny = 38'(pose_y_q) + 38'(yr_q);

		// velocity numerators: magnitude * 1e6
		sumvl  = vla_q + (vlb_q[0] ? {1'b0, vl_q} : '0);
		sumva  = vaa_q + (vab_q[0] ? {1'b0, va_q} : '0);
		prod_l = {vla_q[41:0], vlb_q};
		prod_a = {vaa_q[41:0], vab_q};
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_d   = state_q;
		cnt_d     = '0;
		accept    = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		counts.ready = 1'b0;
		unique case (state_q)
			dod_pkg::ST_IDLE: begin
				counts.ready = 1'b1;
				if (counts.valid) begin
					accept  = 1'b1;
					state_d = dod_pkg::ST_MUL1;
				end
			end
			dod_pkg::ST_MUL1: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					state_d = dod_pkg::ST_SUM;
			end
			dod_pkg::ST_SUM: state_d = dod_pkg::ST_SAT;
			dod_pkg::ST_SAT: state_d = dod_pkg::ST_MUL2;
			dod_pkg::ST_MUL2: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					state_d = dod_pkg::ST_RND;
			end
			dod_pkg::ST_RND: state_d = dod_pkg::ST_UPD;
			dod_pkg::ST_UPD: state_d = dod_pkg::ST_MUL3;
			dod_pkg::ST_MUL3: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd19)
					state_d = dod_pkg::ST_DIVS;
			end
			dod_pkg::ST_DIVS: begin
				div_start = 1'b1;
				state_d   = dod_pkg::ST_DIV;
			end
			dod_pkg::ST_DIV: begin
				if (div_l_o.done)
					state_d = dod_pkg::ST_DONE;
			end
			dod_pkg::ST_DONE: begin
				if (!ovld_q || pose.ready) begin
					load_out = 1'b1;
					state_d  = dod_pkg::ST_IDLE;
				end
			end
			default: state_d = dod_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dod_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// ---------------- config, pose state, output valid ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lmpt_q   <= '0;
			rmpt_q   <= '0;
			apm_q    <= '0;
			last_l_q <= '0;
			last_r_q <= '0;
			pose_x_q <= '0;
			pose_y_q <= '0;
			hd_q     <= '0;
			ovld_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					dod_pkg::REG_LEFT_MPT:  lmpt_q <= cfg.data;
					dod_pkg::REG_RIGHT_MPT: rmpt_q <= cfg.data;
					dod_pkg::REG_ANGLE_PM:  apm_q  <= cfg.data;
					default: ;
				endcase
			end
			if (accept) begin
				last_l_q <= lc_cb;
				last_r_q <= rc_cb;
			end
			// heading moves only after the CORDIC has taken the old one
			if (state_q == dod_pkg::ST_RND)
				hd_q <= hd_q + ht[55:40];
			if (state_q == dod_pkg::ST_UPD) begin
				if (nx > dod_pkg::POS_MAX)
					pose_x_q <= 32'(dod_pkg::POS_MAX);
				else if (nx < dod_pkg::POS_MIN)
					pose_x_q <= 32'(dod_pkg::POS_MIN);
				else
					pose_x_q <= 32'(nx);
				if (ny > dod_pkg::POS_MAX)
					pose_y_q <= 32'(dod_pkg::POS_MAX);
				else if (ny < dod_pkg::POS_MIN)
					pose_y_q <= 32'(dod_pkg::POS_MIN);
				else
					pose_y_q <= 32'(ny);
			end
			if (load_out)
				ovld_q <= 1'b1;
			else if (pose.ready)
				ovld_q <= 1'b0;
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			dod_pkg::ST_IDLE: begin
				if (accept) begin
					dt_q    <= counts.elapsed_us;
					dlt_l_q <= signed'(lc_cb - last_l_q);
					dlt_r_q <= signed'(rc_cb - last_r_q);
					mla_q   <= '0;
					mra_q   <= '0;
					mlb_q   <= lmpt_q;
					mrb_q   <= rmpt_q;
				end
			end
			dod_pkg::ST_MUL1: begin
				mla_q <= {sum_l[COUNT_BITS], sum_l[COUNT_BITS:1]};
				mra_q <= {sum_r[COUNT_BITS], sum_r[COUNT_BITS:1]};
				mlb_q <= {sum_l[0], mlb_q[31:1]};
				mrb_q <= {sum_r[0], mrb_q[31:1]};
			end
			dod_pkg::ST_SUM: begin
				d_q    <= sum_d >>> 1;
				diff_q <= 66'(dr) - 66'(dl);
			end
			dod_pkg::ST_SAT: begin
				d16_q  <= d16_sum[41:8];
				dmag_q <= dsat[41] ? 41'(-dsat) : 41'(dsat);
				lneg_q <= dsat[41];
				mag_q  <= diff_q[65] ? 64'(-diff_q) : 64'(diff_q);
				aneg_q <= diff_q[65];
				mxa_q  <= '0;
				mya_q  <= '0;
				mxb_q  <= cor_o.cos_v;
				myb_q  <= cor_o.sin_v;
				mqa_q  <= '0;
				mqb_q  <= apm_q;
			end
			dod_pkg::ST_MUL2: begin
				mxa_q <= {sumx[34], sumx[34:1]};
				mya_q <= {sumy[34], sumy[34:1]};
				mxb_q <= {sumx[0], mxb_q[31:1]};
				myb_q <= {sumy[0], myb_q[31:1]};
				mqa_q <= {1'b0, sumq[64:1]};
				mqb_q <= {sumq[0], mqb_q[31:1]};
			end
			dod_pkg::ST_RND: begin
				xr_q  <= pxr[66:30];
				yr_q  <= pyr[66:30];
				vl_q  <= {1'b0, dmag_q};
				va_q  <= a8;
				vla_q <= '0;
				vaa_q <= '0;
				vlb_q <= dod_pkg::US_PER_S;
				vab_q <= dod_pkg::US_PER_S;
			end
			dod_pkg::ST_UPD: ;
			dod_pkg::ST_MUL3: begin
				vla_q <= {1'b0, sumvl[42:1]};
				vaa_q <= {1'b0, sumva[42:1]};
				vlb_q <= {sumvl[0], vlb_q[19:1]};
				vab_q <= {sumva[0], vab_q[19:1]};
			end
			dod_pkg::ST_DIVS: ;
			dod_pkg::ST_DIV: begin
				if (div_l_o.done) begin
					lin_q <= (dt_q == '0) ? '0 : div_l_o.quo;
					ang_q <= (dt_q == '0) ? '0 : div_a_o.quo;
				end
			end
			dod_pkg::ST_DONE: begin
				if (load_out) begin
					opx_q  <= pose_x_q;
					opy_q  <= pose_y_q;
					ohd_q  <= hd_q;
					olin_q <= lin_q;
					oang_q <= ang_q;
					ozi_q  <= dt_q == '0;
				end
			end
			default: ;
		endcase
	end

	assign pose.valid            = ovld_q;
	assign pose.position_x       = opx_q;
	assign pose.position_y       = opy_q;
	assign pose.heading_out      = ohd_q;
	assign pose.linear_velocity  = olin_q;
	assign pose.angular_velocity = oang_q;
	assign pose.zero_interval    = ozi_q;

	// ---------------- assertions ----------------
	`DOD_ASSERT_IMPL(a_cordic_window, cor_o.done, state_q == dod_pkg::ST_MUL1, "CORDIC result arrived outside the wheel multiply pass")
	`DOD_ASSERT_IMPL(a_div_pair, div_l_o.done, state_q == dod_pkg::ST_DIV && div_a_o.done, "dividers out of step with the sequencer")
	`DOD_ASSERT_IMPL(a_zero_dt, pose.valid && pose.zero_interval, pose.linear_velocity == 32'sd0 && pose.angular_velocity == 32'sd0, "velocity not forced to zero on zero interval")
	`DOD_ASSERT_NEXT(a_accept_busy, counts.valid && counts.ready, state_q == dod_pkg::ST_MUL1 && !counts.ready, "accepted word did not start the multiply pass")
endmodule
